// ===== rtl/core/bdlp_pkg.sv =====
// Shared types and constants for the button debounce and long-press block
`timescale 1ns / 1ps

package bdlp_pkg;

    typedef logic [2:0] event_t;

    localparam event_t EV_NONE     = 3'd0;
    localparam event_t EV_PRESSED  = 3'd1;
    localparam event_t EV_CLICK    = 3'd2;
    localparam event_t EV_LONG     = 3'd3;
    localparam event_t EV_RELEASED = 3'd4;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_ACTIVE_LOW = 2'd2;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic        ACTIVE_LOW_RESET = 1'b1;

    localparam int PIN_COUNT = 3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [2:0]  pin_levels;
        logic [1:0]  button_index;
    } req_t;

    typedef struct packed {
        event_t     popped_event;
        logic [2:0] pressed_now;
    } rsp_t;

    typedef struct packed {
        logic [15:0] debounce_time_ms;
        logic [15:0] long_hold_ms;
        logic        pins_active_low;
    } cfg_t;

    typedef struct packed {
        logic        tick;
        logic        clear;
        logic        pressed;
        logic [31:0] now_ms;
    } lane_ctrl_t;

endpackage

// ===== rtl/core/bdlp_lane.sv =====
// One button: debounce, pressed and hold state machine with latched event
`timescale 1ns / 1ps

module bdlp_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  bdlp_pkg::lane_ctrl_t ctrl,
    input  bdlp_pkg::cfg_t      cfg,
    output bdlp_pkg::event_t    pending_event
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_PRESSED  = 2'd2;
    localparam logic [1:0] PH_HOLD     = 2'd3;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [31:0]      start_reg;
    logic [31:0]      start_next;
    bdlp_pkg::event_t event_reg;
    bdlp_pkg::event_t event_next;
    logic [31:0]      elapsed;

    assign elapsed = ctrl.now_ms - start_reg;

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        event_next = event_reg;
        if (ctrl.clear)
        begin
            event_next = bdlp_pkg::EV_NONE;
        end
        if (ctrl.tick)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (ctrl.pressed)
                    begin
                        phase_next = PH_DEBOUNCE;
                        start_next = ctrl.now_ms;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (!ctrl.pressed)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (elapsed >= {16'd0, cfg.debounce_time_ms})
                    begin
                        phase_next = PH_PRESSED;
                        event_next = bdlp_pkg::EV_PRESSED;
                        start_next = ctrl.now_ms;
                    end
                end
                PH_PRESSED:
                begin
                    if (!ctrl.pressed)
                    begin
                        phase_next = PH_IDLE;
                        event_next = bdlp_pkg::EV_CLICK;
                    end
                    else if (elapsed >= {16'd0, cfg.long_hold_ms})
                    begin
                        phase_next = PH_HOLD;
                        event_next = bdlp_pkg::EV_LONG;
                    end
                end
                PH_HOLD:
                begin
                    if (!ctrl.pressed)
                    begin
                        phase_next = PH_IDLE;
                        event_next = bdlp_pkg::EV_RELEASED;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            event_reg <= bdlp_pkg::EV_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            event_reg <= event_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

    assign pending_event = event_reg;

endmodule

// ===== rtl/core/bdlp_merge.sv =====
// Picks the popped event from the lanes and holds the result item
`timescale 1ns / 1ps

module bdlp_merge
#(
    parameter int NUM_BUTTONS = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  bdlp_pkg::req_t   req,
    input  bdlp_pkg::event_t lane_event [NUM_BUTTONS],
    input  logic [2:0]       pressed_now,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output bdlp_pkg::rsp_t   rsp
);

    logic             valid_reg;
    logic             valid_next;
    bdlp_pkg::rsp_t   rsp_reg;
    bdlp_pkg::event_t sel_event;
    logic             accept;

    assign req_ready = !valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        sel_event = bdlp_pkg::EV_NONE;
        if (req.cmd == bdlp_pkg::CMD_POP)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (32'(req.button_index) == i + 1)
                begin
                    sel_event = lane_event[i];
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.popped_event <= sel_event;
            rsp_reg.pressed_now  <= pressed_now;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/button_debounce_long_press.sv =====
// Top level: register port, per-button lanes and result merge
// The result is registered and shows in the cycle after its item is accepted.
// Throughput: one item per cycle unless rsp_ready stalls; every lane's subtract
// and compare run in the accepting cycle; the result register frees once taken.
// Reset (rst_n, asynchronous, active low): all buttons idle, no events pending,
// registers back to 50 ms debounce, 1000 ms long press, active-low pins.
`timescale 1ns / 1ps

module button_debounce_long_press
#(
    parameter int NUM_BUTTONS = 3
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bdlp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bdlp_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    bdlp_pkg::cfg_t       cfg_reg;
    logic                 cfg_wr;
    logic                 accept;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [2:0]           pressed_now;
    bdlp_pkg::event_t     lane_event [NUM_BUTTONS];

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time_ms <= bdlp_pkg::DEBOUNCE_RESET;
            cfg_reg.long_hold_ms     <= bdlp_pkg::LONG_PRESS_RESET;
            cfg_reg.pins_active_low  <= bdlp_pkg::ACTIVE_LOW_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                bdlp_pkg::REG_DEBOUNCE:   cfg_reg.debounce_time_ms <= pwdata[15:0];
                bdlp_pkg::REG_LONG_PRESS: cfg_reg.long_hold_ms     <= pwdata[15:0];
                bdlp_pkg::REG_ACTIVE_LOW: cfg_reg.pins_active_low  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bdlp_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg_reg.debounce_time_ms};
            bdlp_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_hold_ms};
            bdlp_pkg::REG_ACTIVE_LOW: prdata = {31'd0, cfg_reg.pins_active_low};
            default:                  prdata = 32'd0;
        endcase
    end

    assign accept = req_valid && req_ready;

    // buttons beyond the pin field see level 0
    genvar gi;
    generate
        for (gi = 0; gi < NUM_BUTTONS; gi++)
        begin : g_lane
            logic                 level;
            bdlp_pkg::lane_ctrl_t ctrl;

            if (gi < bdlp_pkg::PIN_COUNT)
            begin : g_pin
                assign level = req.pin_levels[gi];
            end
            else
            begin : g_nopin
                assign level = 1'b0;
            end

            assign pressed[gi]  = cfg_reg.pins_active_low ? !level : level;
            assign ctrl.tick    = accept && (req.cmd == bdlp_pkg::CMD_UPDATE);
            assign ctrl.clear   = accept && (req.cmd == bdlp_pkg::CMD_POP)
                                  && (32'(req.button_index) == gi + 1);
            assign ctrl.pressed = pressed[gi];
            assign ctrl.now_ms  = req.now_ms;

            bdlp_lane u_lane
            (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .cfg           (cfg_reg),
                .pending_event (lane_event[gi])
            );
        end

        for (gi = 0; gi < bdlp_pkg::PIN_COUNT; gi++)
        begin : g_pn
            if (gi < NUM_BUTTONS)
            begin : g_used
                assign pressed_now[gi] = pressed[gi];
            end
            else
            begin : g_unused
                assign pressed_now[gi] = 1'b0;
            end
        end
    endgenerate

    bdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .lane_event  (lane_event),
        .pressed_now (pressed_now),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

// ===== rtl/core/bdlp_checker.sv =====
// Port-level checks for the button debounce block, bound to the top level
`timescale 1ns / 1ps

module bdlp_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input bdlp_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bdlp_pkg::rsp_t rsp
);

    // every accepted item yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("item accepted without a result");

    // update ticks and pops of no button report no event
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready
        && (req.cmd == bdlp_pkg::CMD_UPDATE || req.button_index == 2'd0)
        |=> rsp.popped_event == bdlp_pkg::EV_NONE)
        else $error("event reported for update or null pop");

    // an empty result register never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled with no result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.popped_event == bdlp_pkg::EV_NONE
                       || rsp.popped_event == bdlp_pkg::EV_PRESSED
                       || rsp.popped_event == bdlp_pkg::EV_CLICK
                       || rsp.popped_event == bdlp_pkg::EV_LONG
                       || rsp.popped_event == bdlp_pkg::EV_RELEASED))
        else $error("undefined event code");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== verif/bdlp_tb_pkg.sv =====
// Scoreboard for the button debounce and long-press block: event prediction and result checks
`timescale 1ns / 1ps

package bdlp_tb_pkg;

    import bdlp_pkg::*;

    localparam int NUM_BUTTONS = 3;

    // no register behind this index; writes must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_DEBOUNCE,
        PHASE_PRESSED,
        PHASE_HOLD
    } button_phase_e;

    class button_event_scoreboard;
        logic [15:0]   debounce_ms;
        logic [15:0]   long_press_ms;
        logic          active_low;
        button_phase_e phase [NUM_BUTTONS];
        logic [31:0]   start_ms [NUM_BUTTONS];
        event_t        latched [NUM_BUTTONS];
        rsp_t          awaited [$];
        int            failures;

        function new();
            debounce_ms   = DEBOUNCE_RESET;
            long_press_ms = LONG_PRESS_RESET;
            active_low    = ACTIVE_LOW_RESET;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                phase[i]    = PHASE_IDLE;
                start_ms[i] = '0;
                latched[i]  = EV_NONE;
            end
            failures = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_DEBOUNCE:   debounce_ms = value[15:0];
                REG_LONG_PRESS: long_press_ms = value[15:0];
                REG_ACTIVE_LOW: active_low = value[0];
                default: ;
            endcase
        endfunction

        function void advance_button(int i, logic held, logic [31:0] now);
            logic [31:0] elapsed;
            elapsed = now - start_ms[i];
            case (phase[i])
                PHASE_IDLE:
                    if (held)
                    begin
                        start_ms[i] = now;
                        phase[i]    = PHASE_DEBOUNCE;
                    end
                PHASE_DEBOUNCE:
                    if (!held)
                        phase[i] = PHASE_IDLE;
                    else if (elapsed >= {16'd0, debounce_ms})
                    begin
                        phase[i]    = PHASE_PRESSED;
                        latched[i]  = EV_PRESSED;
                        start_ms[i] = now;
                    end
                PHASE_PRESSED:
                    if (!held)
                    begin
                        phase[i]   = PHASE_IDLE;
                        latched[i] = EV_CLICK;
                    end
                    else if (elapsed >= {16'd0, long_press_ms})
                    begin
                        phase[i]   = PHASE_HOLD;
                        latched[i] = EV_LONG;
                    end
                default:
                    if (!held)
                    begin
                        phase[i]   = PHASE_IDLE;
                        latched[i] = EV_RELEASED;
                    end
            endcase
        endfunction

        function void note_request(req_t item);
            logic [2:0] pressed;
            rsp_t       want;
            int         k;
            for (int i = 0; i < PIN_COUNT; i++)
                pressed[i] = active_low ? ~item.pin_levels[i] : item.pin_levels[i];
            want.popped_event = EV_NONE;
            want.pressed_now  = pressed;
            if (item.cmd == CMD_UPDATE)
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                    advance_button(i, pressed[i], item.now_ms);
            end
            else if (item.button_index >= 1 && item.button_index <= NUM_BUTTONS)
            begin
                k = int'(item.button_index) - 1;
                want.popped_event = latched[k];
                latched[k] = EV_NONE;
            end
            awaited.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no item outstanding: popped_event %0d pressed_now %b",
                       got.popped_event, got.pressed_now);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.popped_event !== want.popped_event)
            begin
                $error("popped_event: expected %0d, actual %0d",
                       want.popped_event, got.popped_event);
                failures++;
            end
            if (got.pressed_now !== want.pressed_now)
            begin
                $error("pressed_now: expected %b, actual %b", want.pressed_now, got.pressed_now);
                failures++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void finish_check();
            if (awaited.size() != 0)
            begin
                $error("%0d results never arrived", awaited.size());
                failures += awaited.size();
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench for button_debounce_long_press: stimulus, handshakes and watchdog
`timescale 1ns / 1ps

module tb_top;

    import bdlp_pkg::*;
    import bdlp_tb_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    button_event_scoreboard sb = new();

    int          burst_left = 0;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          idle_cycles = 0;
    logic [31:0] clock_ms = '0;
    logic [2:0]  held_want = '0;

    button_debounce_long_press #(.NUM_BUTTONS(NUM_BUTTONS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: own stall pattern, plus long hold-offs on request
    ready_mode_e ready_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_left == 0 && holds_served != holds_asked)
        begin
            hold_left = LONG_HOLD;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (ready_mode)
                READY_ALWAYS:   rsp_ready <= 1'b1;
                READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
                default:        rsp_ready <= (mode_left % 4 != 0);
            endcase
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_item(input req_t item);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sb.note_request(item);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(index, value);
        @(posedge clk);
    endtask

    function automatic req_t update_item(input logic [31:0] now, input logic [2:0] pins);
        req_t r;
        r.cmd          = CMD_UPDATE;
        r.now_ms       = now;
        r.pin_levels   = pins;
        r.button_index = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic req_t pop_item(input logic [1:0] index);
        req_t r;
        r.cmd          = CMD_POP;
        r.now_ms       = $urandom;
        r.pin_levels   = 3'($urandom_range(0, 7));
        r.button_index = index;
        return r;
    endfunction

    function automatic logic [31:0] next_step();
        int unsigned span;
        span = (int'(sb.debounce_ms) + int'(sb.long_press_ms)) / 3 + 4;
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1:       return 32'd0;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    // mostly coherent press sequences on a rising clock, some pops and bounce noise
    function automatic req_t random_item();
        req_t r;
        if ($urandom_range(0, 9) < 3)
            return pop_item(2'($urandom_range(0, 3)));
        for (int i = 0; i < NUM_BUTTONS; i++)
            if ($urandom_range(0, 11) == 0)
                held_want[i] = ~held_want[i];
        clock_ms += next_step();
        r = update_item(clock_ms, sb.active_low ? ~held_want : held_want);
        if ($urandom_range(0, 9) == 0)
            r.pin_levels = 3'($urandom_range(0, 7));
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_item(random_item());
    endtask

    // reset settings: 50 ms debounce, 1000 ms long press, active-low pins
    task automatic run_directed();
        send_item(pop_item(2'd0));
        send_item(pop_item(2'd1));
        send_item(update_item(32'hFFFF_FFF0, 3'b111));
        send_item(update_item(32'hFFFF_FFF0, 3'b000));
        send_item(update_item(32'hFFFF_FFFF, 3'b000));
        send_item(update_item(32'h0000_0021, 3'b000));
        send_item(update_item(32'h0000_0022, 3'b000));
        send_item(pop_item(2'd1));
        send_item(pop_item(2'd1));
        send_item(update_item(32'h0000_0409, 3'b100));
        send_item(pop_item(2'd3));
        send_item(update_item(32'h0000_040A, 3'b100));
        send_item(pop_item(2'd2));
        send_item(update_item(32'h0000_040B, 3'b111));
        send_item(pop_item(2'd1));
        send_item(pop_item(2'd2));
        send_item(update_item(32'h0000_0500, 3'b011));
        send_item(update_item(32'h0000_0510, 3'b111));
        send_item(update_item(32'h0000_0520, 3'b011));
        send_item(update_item(32'h0000_0552, 3'b011));
        send_item(pop_item(2'd3));
        send_item(update_item(32'hFFFF_FFFF, 3'b011));
        send_item(pop_item(2'd3));
        send_item(pop_item(2'd3));
        send_item(update_item(32'h0000_0000, 3'b111));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        clock_ms = 32'h0000_1000;
        run_random(150);
        drain();

        apb_write(REG_DEBOUNCE, 32'd0);
        apb_write(REG_LONG_PRESS, 32'd0);
        apb_write(REG_ACTIVE_LOW, 32'd0);
        run_random(150);
        drain();

        // upper bits must be masked off
        apb_write(REG_DEBOUNCE, 32'hFFFF_FFFF);
        apb_write(REG_LONG_PRESS, 32'h0001_FFFF);
        apb_write(REG_ACTIVE_LOW, 32'hFFFF_FFFF);
        clock_ms = 32'hFFF0_0000;
        run_random(150);
        drain();

        apb_write(REG_DEBOUNCE, 32'hABCD_0003);
        apb_write(REG_LONG_PRESS, 32'd12);
        apb_write(REG_ACTIVE_LOW, 32'h0000_0002);
        apb_write(REG_UNUSED, 32'h0000_0001);
        run_random(60);
        holds_asked++;
        run_random(90);
        drain();

        repeat (3)
        begin
            apb_write(REG_DEBOUNCE, 32'($urandom_range(0, 40)));
            apb_write(REG_LONG_PRESS, 32'($urandom_range(0, 120)));
            apb_write(REG_ACTIVE_LOW, 32'($urandom_range(0, 1)));
            run_random(80);
            drain();
        end

        repeat (4) @(posedge clk);
        sb.finish_check();
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
